// File: sv/mos6502_instruction_stream_decoder_top_assert.svh
// Assertion macros for the 6502 stream decoder
`ifndef MOS6502_INSTRUCTION_STREAM_DECODER_TOP_ASSERT_SVH
`define MOS6502_INSTRUCTION_STREAM_DECODER_TOP_ASSERT_SVH

// implication checked on every clock, off in reset
`define M6D_ASSERT_IMPL(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define M6D_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: sv/m6d_pkg.sv
package m6d_pkg;

    localparam int unsigned QDEPTH = 2;

    // addressing modes
    localparam logic [3:0] MODE_IMP = 4'd0;
    localparam logic [3:0] MODE_IMM = 4'd1;
    localparam logic [3:0] MODE_ABS = 4'd2;
    localparam logic [3:0] MODE_ABX = 4'd3;
    localparam logic [3:0] MODE_ABY = 4'd4;
    localparam logic [3:0] MODE_ZPG = 4'd5;
    localparam logic [3:0] MODE_IZX = 4'd6;
    localparam logic [3:0] MODE_IZY = 4'd7;
    localparam logic [3:0] MODE_ZPX = 4'd8;
    localparam logic [3:0] MODE_ZPY = 4'd9;
    localparam logic [3:0] MODE_IND = 4'd10;
    localparam logic [3:0] MODE_REL = 4'd11;

    // completed instruction handed from front to back
    typedef struct packed {
        logic [15:0] addr;
        logic [7:0]  opcode;
        logic [7:0]  op_lo;
        logic [7:0]  op_hi;
        logic [1:0]  len;
        logic [3:0]  mode;
        logic [14:0] mnem;
        logic        trunc;
    } instr_t;

    // result word
    typedef struct packed {
        logic        trunc;
        logic [15:0] target;
        logic [14:0] mnem;
        logic [3:0]  mode;
        logic [1:0]  len;
        logic [7:0]  op_hi;
        logic [7:0]  op_lo;
        logic [7:0]  opcode;
        logic [15:0] addr;
    } result_t;

    function automatic logic [1:0] mode_len(input logic [3:0] m);
        logic [1:0] r;
        case (m)
            MODE_IMP: r = 2'd1;
            MODE_ABS, MODE_ABX, MODE_ABY, MODE_IND: r = 2'd3;
            MODE_IMM, MODE_ZPG, MODE_IZX, MODE_IZY, MODE_ZPX, MODE_ZPY, MODE_REL: r = 2'd2;
            default: r = 2'd1;
        endcase
        return r;
    endfunction

    function automatic logic [14:0] pk(input byte a, input byte b, input byte c);
        logic [7:0] x;
        logic [7:0] y;
        logic [7:0] z;
        x = a - 8'd64;
        y = b - 8'd64;
        z = c - 8'd64;
        return {x[4:0], y[4:0], z[4:0]};
    endfunction

    // table entry: {mnemonic, documented, mode}
    function automatic logic [19:0] op_entry(input logic [7:0] opc);
        logic [14:0] mn;
        logic        doc;
        logic [3:0]  md;
        mn = '0;
        doc = 1'b0;
        md = MODE_IMP;
        unique case (opc)
            8'h00: begin mn = pk("B","R","K"); doc = 1'b1; md = MODE_IMP; end
            8'h01: begin mn = pk("O","R","A"); doc = 1'b1; md = MODE_IZX; end
            8'h02: begin mn = pk("K","I","L"); md = MODE_IMP; end
            8'h03: begin mn = pk("S","L","O"); md = MODE_IZX; end
            8'h04: begin mn = pk("N","O","P"); md = MODE_ZPG; end
            8'h05: begin mn = pk("O","R","A"); doc = 1'b1; md = MODE_ZPG; end
            8'h06: begin mn = pk("A","S","L"); doc = 1'b1; md = MODE_ZPG; end
            8'h07: begin mn = pk("S","L","O"); md = MODE_ZPG; end
            8'h08: begin mn = pk("P","H","P"); doc = 1'b1; md = MODE_IMP; end
            8'h09: begin mn = pk("O","R","A"); doc = 1'b1; md = MODE_IMM; end
            8'h0A: begin mn = pk("A","S","L"); doc = 1'b1; md = MODE_IMP; end
            8'h0B: begin mn = pk("A","N","C"); md = MODE_IMM; end
            8'h0C: begin mn = pk("N","O","P"); md = MODE_ABS; end
            8'h0D: begin mn = pk("O","R","A"); doc = 1'b1; md = MODE_ABS; end
            8'h0E: begin mn = pk("A","S","L"); doc = 1'b1; md = MODE_ABS; end
            8'h0F: begin mn = pk("S","L","O"); md = MODE_ABS; end
            8'h10: begin mn = pk("B","P","L"); doc = 1'b1; md = MODE_REL; end
            8'h11: begin mn = pk("O","R","A"); doc = 1'b1; md = MODE_IZY; end
            8'h12: begin mn = pk("K","I","L"); md = MODE_IMP; end
            8'h13: begin mn = pk("S","L","O"); md = MODE_IZY; end
            8'h14: begin mn = pk("N","O","P"); md = MODE_ZPX; end
            8'h15: begin mn = pk("O","R","A"); doc = 1'b1; md = MODE_ZPX; end
            8'h16: begin mn = pk("A","S","L"); doc = 1'b1; md = MODE_ZPX; end
            8'h17: begin mn = pk("S","L","O"); md = MODE_ZPX; end
            8'h18: begin mn = pk("C","L","C"); doc = 1'b1; md = MODE_IMP; end
            8'h19: begin mn = pk("O","R","A"); doc = 1'b1; md = MODE_ABY; end
            8'h1A: begin mn = pk("N","O","P"); md = MODE_IMP; end
            8'h1B: begin mn = pk("S","L","O"); md = MODE_ABY; end
            8'h1C: begin mn = pk("N","O","P"); md = MODE_ABX; end
            8'h1D: begin mn = pk("O","R","A"); doc = 1'b1; md = MODE_ABX; end
            8'h1E: begin mn = pk("A","S","L"); doc = 1'b1; md = MODE_ABX; end
            8'h1F: begin mn = pk("S","L","O"); md = MODE_ABX; end
            8'h20: begin mn = pk("J","S","R"); doc = 1'b1; md = MODE_ABS; end
            8'h21: begin mn = pk("A","N","D"); doc = 1'b1; md = MODE_IZX; end
            8'h22: begin mn = pk("K","I","L"); md = MODE_IMP; end
            8'h23: begin mn = pk("R","L","A"); md = MODE_IZX; end
            8'h24: begin mn = pk("B","I","T"); doc = 1'b1; md = MODE_ZPG; end
            8'h25: begin mn = pk("A","N","D"); doc = 1'b1; md = MODE_ZPG; end
            8'h26: begin mn = pk("R","O","L"); doc = 1'b1; md = MODE_ZPG; end
            8'h27: begin mn = pk("R","L","A"); md = MODE_ZPG; end
            8'h28: begin mn = pk("P","L","P"); doc = 1'b1; md = MODE_IMP; end
            8'h29: begin mn = pk("A","N","D"); doc = 1'b1; md = MODE_IMM; end
            8'h2A: begin mn = pk("R","O","L"); doc = 1'b1; md = MODE_IMP; end
            8'h2B: begin mn = pk("A","N","C"); md = MODE_IMM; end
            8'h2C: begin mn = pk("B","I","T"); doc = 1'b1; md = MODE_ABS; end
            8'h2D: begin mn = pk("A","N","D"); doc = 1'b1; md = MODE_ABS; end
            8'h2E: begin mn = pk("R","O","L"); doc = 1'b1; md = MODE_ABS; end
            8'h2F: begin mn = pk("R","L","A"); md = MODE_ABS; end
            8'h30: begin mn = pk("B","M","I"); doc = 1'b1; md = MODE_REL; end
            8'h31: begin mn = pk("A","N","D"); doc = 1'b1; md = MODE_IZY; end
            8'h32: begin mn = pk("K","I","L"); md = MODE_IMP; end
            8'h33: begin mn = pk("R","L","A"); md = MODE_IZY; end
            8'h34: begin mn = pk("N","O","P"); md = MODE_ZPX; end
            8'h35: begin mn = pk("A","N","D"); doc = 1'b1; md = MODE_ZPX; end
            8'h36: begin mn = pk("R","O","L"); doc = 1'b1; md = MODE_ZPX; end
            8'h37: begin mn = pk("R","L","A"); md = MODE_ZPX; end
            8'h38: begin mn = pk("S","E","C"); doc = 1'b1; md = MODE_IMP; end
            8'h39: begin mn = pk("A","N","D"); doc = 1'b1; md = MODE_ABY; end
            8'h3A: begin mn = pk("N","O","P"); md = MODE_IMP; end
            8'h3B: begin mn = pk("R","L","A"); md = MODE_ABY; end
            8'h3C: begin mn = pk("N","O","P"); md = MODE_ABX; end
            8'h3D: begin mn = pk("A","N","D"); doc = 1'b1; md = MODE_ABX; end
            8'h3E: begin mn = pk("R","O","L"); doc = 1'b1; md = MODE_ABX; end
            8'h3F: begin mn = pk("R","L","A"); md = MODE_ABX; end
            8'h40: begin mn = pk("R","T","I"); doc = 1'b1; md = MODE_IMP; end
            8'h41: begin mn = pk("E","O","R"); doc = 1'b1; md = MODE_IZX; end
            8'h42: begin mn = pk("K","I","L"); md = MODE_IMP; end
            8'h43: begin mn = pk("S","R","E"); md = MODE_IZX; end
            8'h44: begin mn = pk("N","O","P"); md = MODE_ZPG; end
            8'h45: begin mn = pk("E","O","R"); doc = 1'b1; md = MODE_ZPG; end
            8'h46: begin mn = pk("L","S","R"); doc = 1'b1; md = MODE_ZPG; end
            8'h47: begin mn = pk("S","R","E"); md = MODE_ZPG; end
            8'h48: begin mn = pk("P","H","A"); doc = 1'b1; md = MODE_IMP; end
            8'h49: begin mn = pk("E","O","R"); doc = 1'b1; md = MODE_IMM; end
            8'h4A: begin mn = pk("L","S","R"); doc = 1'b1; md = MODE_IMP; end
            8'h4B: begin mn = pk("A","L","R"); md = MODE_IMM; end
            8'h4C: begin mn = pk("J","M","P"); doc = 1'b1; md = MODE_ABS; end
            8'h4D: begin mn = pk("E","O","R"); doc = 1'b1; md = MODE_ABS; end
            8'h4E: begin mn = pk("L","S","R"); doc = 1'b1; md = MODE_ABS; end
            8'h4F: begin mn = pk("S","R","E"); md = MODE_ABS; end
            8'h50: begin mn = pk("B","V","C"); doc = 1'b1; md = MODE_REL; end
            8'h51: begin mn = pk("E","O","R"); doc = 1'b1; md = MODE_IZY; end
            8'h52: begin mn = pk("K","I","L"); md = MODE_IMP; end
            8'h53: begin mn = pk("S","R","E"); md = MODE_IZY; end
            8'h54: begin mn = pk("N","O","P"); md = MODE_ZPX; end
            8'h55: begin mn = pk("E","O","R"); doc = 1'b1; md = MODE_ZPX; end
            8'h56: begin mn = pk("L","S","R"); doc = 1'b1; md = MODE_ZPX; end
            8'h57: begin mn = pk("S","R","E"); md = MODE_ZPX; end
            8'h58: begin mn = pk("C","L","I"); doc = 1'b1; md = MODE_IMP; end
            8'h59: begin mn = pk("E","O","R"); doc = 1'b1; md = MODE_ABY; end
            8'h5A: begin mn = pk("N","O","P"); md = MODE_IMP; end
            8'h5B: begin mn = pk("S","R","E"); md = MODE_ABY; end
            8'h5C: begin mn = pk("N","O","P"); md = MODE_ABX; end
            8'h5D: begin mn = pk("E","O","R"); doc = 1'b1; md = MODE_ABX; end
            8'h5E: begin mn = pk("L","S","R"); doc = 1'b1; md = MODE_ABX; end
            8'h5F: begin mn = pk("S","R","E"); md = MODE_ABX; end
            8'h60: begin mn = pk("R","T","S"); doc = 1'b1; md = MODE_IMP; end
            8'h61: begin mn = pk("A","D","C"); doc = 1'b1; md = MODE_IZX; end
            8'h62: begin mn = pk("K","I","L"); md = MODE_IMP; end
            8'h63: begin mn = pk("R","R","A"); md = MODE_IZX; end
            8'h64: begin mn = pk("N","O","P"); md = MODE_ZPG; end
            8'h65: begin mn = pk("A","D","C"); doc = 1'b1; md = MODE_ZPG; end
            8'h66: begin mn = pk("R","O","R"); doc = 1'b1; md = MODE_ZPG; end
            8'h67: begin mn = pk("R","R","A"); md = MODE_ZPG; end
            8'h68: begin mn = pk("P","L","A"); doc = 1'b1; md = MODE_IMP; end
            8'h69: begin mn = pk("A","D","C"); doc = 1'b1; md = MODE_IMM; end
            8'h6A: begin mn = pk("R","O","R"); doc = 1'b1; md = MODE_IMP; end
            8'h6B: begin mn = pk("A","R","R"); md = MODE_IMM; end
            8'h6C: begin mn = pk("J","M","P"); doc = 1'b1; md = MODE_IND; end
            8'h6D: begin mn = pk("A","D","C"); doc = 1'b1; md = MODE_ABS; end
            8'h6E: begin mn = pk("R","O","R"); doc = 1'b1; md = MODE_ABS; end
            8'h6F: begin mn = pk("R","R","A"); md = MODE_ABS; end
            8'h70: begin mn = pk("B","V","S"); doc = 1'b1; md = MODE_REL; end
            8'h71: begin mn = pk("A","D","C"); doc = 1'b1; md = MODE_IZY; end
            8'h72: begin mn = pk("K","I","L"); md = MODE_IMP; end
            8'h73: begin mn = pk("R","R","A"); md = MODE_IZY; end
            8'h74: begin mn = pk("N","O","P"); md = MODE_ZPX; end
            8'h75: begin mn = pk("A","D","C"); doc = 1'b1; md = MODE_ZPX; end
            8'h76: begin mn = pk("R","O","R"); doc = 1'b1; md = MODE_ZPX; end
            8'h77: begin mn = pk("R","R","A"); md = MODE_ZPX; end
            8'h78: begin mn = pk("S","E","I"); doc = 1'b1; md = MODE_IMP; end
            8'h79: begin mn = pk("A","D","C"); doc = 1'b1; md = MODE_ABY; end
            8'h7A: begin mn = pk("N","O","P"); md = MODE_IMP; end
            8'h7B: begin mn = pk("R","R","A"); md = MODE_ABY; end
            8'h7C: begin mn = pk("N","O","P"); md = MODE_ABX; end
            8'h7D: begin mn = pk("A","D","C"); doc = 1'b1; md = MODE_ABX; end
            8'h7E: begin mn = pk("R","O","R"); doc = 1'b1; md = MODE_ABX; end
            8'h7F: begin mn = pk("R","R","A"); md = MODE_ABX; end
            8'h80: begin mn = pk("N","O","P"); md = MODE_IMM; end
            8'h81: begin mn = pk("S","T","A"); doc = 1'b1; md = MODE_IZX; end
            8'h82: begin mn = pk("N","O","P"); md = MODE_IMM; end
            8'h83: begin mn = pk("S","A","X"); md = MODE_IZX; end
            8'h84: begin mn = pk("S","T","Y"); doc = 1'b1; md = MODE_ZPG; end
            8'h85: begin mn = pk("S","T","A"); doc = 1'b1; md = MODE_ZPG; end
            8'h86: begin mn = pk("S","T","X"); doc = 1'b1; md = MODE_ZPG; end
            8'h87: begin mn = pk("S","A","X"); md = MODE_ZPG; end
            8'h88: begin mn = pk("D","E","Y"); doc = 1'b1; md = MODE_IMP; end
            8'h89: begin mn = pk("N","O","P"); md = MODE_IMM; end
            8'h8A: begin mn = pk("T","X","A"); doc = 1'b1; md = MODE_IMP; end
            8'h8B: begin mn = pk("X","A","A"); md = MODE_IMM; end
            8'h8C: begin mn = pk("S","T","Y"); doc = 1'b1; md = MODE_ABS; end
            8'h8D: begin mn = pk("S","T","A"); doc = 1'b1; md = MODE_ABS; end
            8'h8E: begin mn = pk("S","T","X"); doc = 1'b1; md = MODE_ABS; end
            8'h8F: begin mn = pk("S","A","X"); md = MODE_ABS; end
            8'h90: begin mn = pk("B","C","C"); doc = 1'b1; md = MODE_REL; end
            8'h91: begin mn = pk("S","T","A"); doc = 1'b1; md = MODE_IZY; end
            8'h92: begin mn = pk("K","I","L"); md = MODE_IMP; end
            8'h93: begin mn = pk("A","H","X"); md = MODE_IZY; end
            8'h94: begin mn = pk("S","T","Y"); doc = 1'b1; md = MODE_ZPX; end
            8'h95: begin mn = pk("S","T","A"); doc = 1'b1; md = MODE_ZPX; end
            8'h96: begin mn = pk("S","T","X"); doc = 1'b1; md = MODE_ZPY; end
            8'h97: begin mn = pk("S","A","X"); md = MODE_ZPY; end
            8'h98: begin mn = pk("T","Y","A"); doc = 1'b1; md = MODE_IMP; end
            8'h99: begin mn = pk("S","T","A"); doc = 1'b1; md = MODE_ABY; end
            8'h9A: begin mn = pk("T","X","S"); doc = 1'b1; md = MODE_IMP; end
            8'h9B: begin mn = pk("T","A","S"); md = MODE_ABY; end
            8'h9C: begin mn = pk("S","H","Y"); md = MODE_ABX; end
            8'h9D: begin mn = pk("S","T","A"); doc = 1'b1; md = MODE_ABX; end
            8'h9E: begin mn = pk("S","H","X"); md = MODE_ABY; end
            8'h9F: begin mn = pk("A","H","X"); md = MODE_ABY; end
            8'hA0: begin mn = pk("L","D","Y"); doc = 1'b1; md = MODE_IMM; end
            8'hA1: begin mn = pk("L","D","A"); doc = 1'b1; md = MODE_IZX; end
            8'hA2: begin mn = pk("L","D","X"); doc = 1'b1; md = MODE_IMM; end
            8'hA3: begin mn = pk("L","A","X"); md = MODE_IZX; end
            8'hA4: begin mn = pk("L","D","Y"); doc = 1'b1; md = MODE_ZPG; end
            8'hA5: begin mn = pk("L","D","A"); doc = 1'b1; md = MODE_ZPG; end
            8'hA6: begin mn = pk("L","D","X"); doc = 1'b1; md = MODE_ZPG; end
            8'hA7: begin mn = pk("L","A","X"); md = MODE_ZPG; end
            8'hA8: begin mn = pk("T","A","Y"); doc = 1'b1; md = MODE_IMP; end
            8'hA9: begin mn = pk("L","D","A"); doc = 1'b1; md = MODE_IMM; end
            8'hAA: begin mn = pk("T","A","X"); doc = 1'b1; md = MODE_IMP; end
            8'hAB: begin mn = pk("L","A","X"); md = MODE_IMM; end
            8'hAC: begin mn = pk("L","D","Y"); doc = 1'b1; md = MODE_ABS; end
            8'hAD: begin mn = pk("L","D","A"); doc = 1'b1; md = MODE_ABS; end
            8'hAE: begin mn = pk("L","D","X"); doc = 1'b1; md = MODE_ABS; end
            8'hAF: begin mn = pk("L","A","X"); md = MODE_ABS; end
            8'hB0: begin mn = pk("B","C","S"); doc = 1'b1; md = MODE_REL; end
            8'hB1: begin mn = pk("L","D","A"); doc = 1'b1; md = MODE_IZY; end
            8'hB2: begin mn = pk("K","I","L"); md = MODE_IMP; end
            8'hB3: begin mn = pk("L","A","X"); md = MODE_IZY; end
            8'hB4: begin mn = pk("L","D","Y"); doc = 1'b1; md = MODE_ZPX; end
            8'hB5: begin mn = pk("L","D","A"); doc = 1'b1; md = MODE_ZPX; end
            8'hB6: begin mn = pk("L","D","X"); doc = 1'b1; md = MODE_ZPY; end
            8'hB7: begin mn = pk("L","A","X"); md = MODE_ZPY; end
            8'hB8: begin mn = pk("C","L","V"); doc = 1'b1; md = MODE_IMP; end
            8'hB9: begin mn = pk("L","D","A"); doc = 1'b1; md = MODE_ABY; end
            8'hBA: begin mn = pk("T","S","X"); doc = 1'b1; md = MODE_IMP; end
            8'hBB: begin mn = pk("L","A","S"); md = MODE_ABY; end
            8'hBC: begin mn = pk("L","D","Y"); doc = 1'b1; md = MODE_ABX; end
            8'hBD: begin mn = pk("L","D","A"); doc = 1'b1; md = MODE_ABX; end
            8'hBE: begin mn = pk("L","D","X"); doc = 1'b1; md = MODE_ABY; end
            8'hBF: begin mn = pk("L","A","X"); md = MODE_ABY; end
            8'hC0: begin mn = pk("C","P","Y"); doc = 1'b1; md = MODE_IMM; end
            8'hC1: begin mn = pk("C","M","P"); doc = 1'b1; md = MODE_IZX; end
            8'hC2: begin mn = pk("N","O","P"); md = MODE_IMM; end
            8'hC3: begin mn = pk("D","C","P"); md = MODE_IZX; end
            8'hC4: begin mn = pk("C","P","Y"); doc = 1'b1; md = MODE_ZPG; end
            8'hC5: begin mn = pk("C","M","P"); doc = 1'b1; md = MODE_ZPG; end
            8'hC6: begin mn = pk("D","E","C"); doc = 1'b1; md = MODE_ZPG; end
            8'hC7: begin mn = pk("D","C","P"); md = MODE_ZPG; end
            8'hC8: begin mn = pk("I","N","Y"); doc = 1'b1; md = MODE_IMP; end
            8'hC9: begin mn = pk("C","M","P"); doc = 1'b1; md = MODE_IMM; end
            8'hCA: begin mn = pk("D","E","X"); doc = 1'b1; md = MODE_IMP; end
            8'hCB: begin mn = pk("A","X","S"); md = MODE_IMM; end
            8'hCC: begin mn = pk("C","P","Y"); doc = 1'b1; md = MODE_ABS; end
            8'hCD: begin mn = pk("C","M","P"); doc = 1'b1; md = MODE_ABS; end
            8'hCE: begin mn = pk("D","E","C"); doc = 1'b1; md = MODE_ABS; end
            8'hCF: begin mn = pk("D","C","P"); md = MODE_ABS; end
            8'hD0: begin mn = pk("B","N","E"); doc = 1'b1; md = MODE_REL; end
            8'hD1: begin mn = pk("C","M","P"); doc = 1'b1; md = MODE_IZY; end
            8'hD2: begin mn = pk("K","I","L"); md = MODE_IMP; end
            8'hD3: begin mn = pk("D","C","P"); md = MODE_IZY; end
            8'hD4: begin mn = pk("N","O","P"); md = MODE_ZPX; end
            8'hD5: begin mn = pk("C","M","P"); doc = 1'b1; md = MODE_ZPX; end
            8'hD6: begin mn = pk("D","E","C"); doc = 1'b1; md = MODE_ZPX; end
            8'hD7: begin mn = pk("D","C","P"); md = MODE_ZPX; end
            8'hD8: begin mn = pk("C","L","D"); doc = 1'b1; md = MODE_IMP; end
            8'hD9: begin mn = pk("C","M","P"); doc = 1'b1; md = MODE_ABY; end
            8'hDA: begin mn = pk("N","O","P"); md = MODE_IMP; end
            8'hDB: begin mn = pk("D","C","P"); md = MODE_ABY; end
            8'hDC: begin mn = pk("N","O","P"); md = MODE_ABX; end
            8'hDD: begin mn = pk("C","M","P"); doc = 1'b1; md = MODE_ABX; end
            8'hDE: begin mn = pk("D","E","C"); doc = 1'b1; md = MODE_ABX; end
            8'hDF: begin mn = pk("D","C","P"); md = MODE_ABX; end
            8'hE0: begin mn = pk("C","P","X"); doc = 1'b1; md = MODE_IMM; end
            8'hE1: begin mn = pk("S","B","C"); doc = 1'b1; md = MODE_IZX; end
            8'hE2: begin mn = pk("N","O","P"); md = MODE_IMM; end
            8'hE3: begin mn = pk("I","S","C"); md = MODE_IZX; end
            8'hE4: begin mn = pk("C","P","X"); doc = 1'b1; md = MODE_ZPG; end
            8'hE5: begin mn = pk("S","B","C"); doc = 1'b1; md = MODE_ZPG; end
            8'hE6: begin mn = pk("I","N","C"); doc = 1'b1; md = MODE_ZPG; end
            8'hE7: begin mn = pk("I","S","C"); md = MODE_ZPG; end
            8'hE8: begin mn = pk("I","N","X"); doc = 1'b1; md = MODE_IMP; end
            8'hE9: begin mn = pk("S","B","C"); doc = 1'b1; md = MODE_IMM; end
            8'hEA: begin mn = pk("N","O","P"); doc = 1'b1; md = MODE_IMP; end
            8'hEB: begin mn = pk("S","B","C"); md = MODE_IMM; end
            8'hEC: begin mn = pk("C","P","X"); doc = 1'b1; md = MODE_ABS; end
            8'hED: begin mn = pk("S","B","C"); doc = 1'b1; md = MODE_ABS; end
            8'hEE: begin mn = pk("I","N","C"); doc = 1'b1; md = MODE_ABS; end
            8'hEF: begin mn = pk("I","S","C"); md = MODE_ABS; end
            8'hF0: begin mn = pk("B","E","Q"); doc = 1'b1; md = MODE_REL; end
            8'hF1: begin mn = pk("S","B","C"); doc = 1'b1; md = MODE_IZY; end
            8'hF2: begin mn = pk("K","I","L"); md = MODE_IMP; end
            8'hF3: begin mn = pk("I","S","C"); md = MODE_IZY; end
            8'hF4: begin mn = pk("N","O","P"); md = MODE_ZPX; end
            8'hF5: begin mn = pk("S","B","C"); doc = 1'b1; md = MODE_ZPX; end
            8'hF6: begin mn = pk("I","N","C"); doc = 1'b1; md = MODE_ZPX; end
            8'hF7: begin mn = pk("I","S","C"); md = MODE_ZPX; end
            8'hF8: begin mn = pk("S","E","D"); doc = 1'b1; md = MODE_IMP; end
            8'hF9: begin mn = pk("S","B","C"); doc = 1'b1; md = MODE_ABY; end
            8'hFA: begin mn = pk("N","O","P"); md = MODE_IMP; end
            8'hFB: begin mn = pk("I","S","C"); md = MODE_ABY; end
            8'hFC: begin mn = pk("N","O","P"); md = MODE_ABX; end
            8'hFD: begin mn = pk("S","B","C"); doc = 1'b1; md = MODE_ABX; end
            8'hFE: begin mn = pk("I","N","C"); doc = 1'b1; md = MODE_ABX; end
            default: begin mn = pk("I","S","C"); md = MODE_ABX; end
        endcase
        return {mn, doc, md};
    endfunction

endpackage

// File: sv/mos6502_instruction_stream_decoder_top.sv
// 6502 instruction stream decoder: one byte per cycle in, one word per instruction out.
// m_tvalid rises once an instruction's last byte has been accepted and has passed
// the queue write and then the output register.
// Throughput: one byte per cycle sustained; input stalls only while the 2-entry queue
// would be full, which can only follow a time when m_tready held off.
// Reset (aresetn low, synchronous): header phase, address 0, table select documented, no results.
module mos6502_instruction_stream_decoder_top (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // stream_byte
    input  logic        s_tlast,   // final_byte
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_data,  // undocumented_set
    output logic        m_tvalid,
    input  logic        m_tready,
    // instr_address, opcode_byte, operand_low, operand_high, instr_length,
    // address_mode, mnemonic_code, branch_target, truncated, zero pad
    output logic [79:0] m_tdata
);
    import m6d_pkg::*;

    `include "mos6502_instruction_stream_decoder_top_assert.svh"

    logic       sel_reg;
    logic       push;
    instr_t     push_data;
    logic       pop;
    instr_t     q_data;
    logic       q_valid;
    logic [1:0] q_count;
    logic [2:0] q_after;
    result_t    res;
    logic       in_fire;

    // config register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sel_reg <= 1'b0;
        end else if (cfg_valid) begin
            sel_reg <= cfg_data;
        end
    end
    assign cfg_ready = 1'b1;

    // accept only when the word this byte may produce next cycle still fits
    assign q_after  = {1'b0, q_count} + {2'b00, push} - {2'b00, pop};
    assign s_tready = (q_after <= 3'd1);
    assign in_fire  = s_tvalid && s_tready;

    m6d_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_byte   (s_tdata),
        .in_last   (s_tlast),
        .in_fire   (in_fire),
        .table_sel (sel_reg),
        .push      (push),
        .push_data (push_data)
    );

    m6d_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_en    (push),
        .wr_data  (push_data),
        .rd_en    (pop),
        .rd_data  (q_data),
        .rd_valid (q_valid),
        .count    (q_count)
    );

    m6d_back u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .q_valid (q_valid),
        .q_data  (q_data),
        .q_pop   (pop),
        .m_valid (m_tvalid),
        .m_ready (m_tready),
        .m_data  (res)
    );

    assign m_tdata = {
        2'b00, res.trunc, res.target, res.mnem, res.mode, res.len,
        res.op_hi, res.op_lo, res.opcode, res.addr
    };

    `M6D_ASSERT_IMPL(a_no_overflow, aclk, aresetn, push, q_count != 2'd2 || pop, "queue overflow")
    `M6D_ASSERT_IMPL(a_no_underflow, aclk, aresetn, pop, q_count != 2'd0, "queue underflow")
    `M6D_ASSERT_NEXT(a_stall, aclk, aresetn, q_count == 2'd2 && !pop, !push || q_count != 2'd2, "push into full queue")

endmodule

// File: sv/m6d_front.sv
// Front end: header capture, opcode classification, operand collection
module m6d_front (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic [7:0]      in_byte,
    input  logic            in_last,
    input  logic            in_fire,
    input  logic            table_sel,
    output logic            push,
    output m6d_pkg::instr_t push_data
);
    import m6d_pkg::*;

    typedef enum logic [2:0] {
        PH_HLO, PH_HHI, PH_OPC, PH_OP1, PH_OP2
    } phase_t;

    phase_t      phase_reg;
    phase_t      phase_next;
    logic        push_reg;
    logic        push_next;
    instr_t      push_data_reg;
    logic [15:0] addr_reg;
    logic [7:0]  opc_reg;
    logic [7:0]  opnd_reg;
    logic [14:0] mnem_reg;
    logic [3:0]  mode_reg;
    logic [1:0]  len_reg;

    logic [19:0] ent;
    logic [14:0] dec_mnem;
    logic [3:0]  dec_mode;
    logic [1:0]  dec_len;

    // table lookup on the incoming byte, blanked when undocumented and not enabled
    always_comb begin
        ent = op_entry(in_byte);
        if (!table_sel && !ent[4]) begin
            dec_mnem = '0;
            dec_mode = MODE_IMP;
        end else begin
            dec_mnem = ent[19:5];
            dec_mode = ent[3:0];
        end
        dec_len = mode_len(dec_mode);
    end

    // next phase and push strobe; a final byte always returns to the header phase
    always_comb begin
        phase_next = phase_reg;
        push_next  = 1'b0;
        if (in_fire) begin
            unique case (phase_reg)
                PH_HHI: phase_next = PH_OPC;
                PH_OPC: begin
                    if (dec_len == 2'd1 || in_last) begin
                        push_next = 1'b1;
                    end else begin
                        phase_next = PH_OP1;
                    end
                end
                PH_OP1: begin
                    if (len_reg == 2'd2 || in_last) begin
                        push_next  = 1'b1;
                        phase_next = PH_OPC;
                    end else begin
                        phase_next = PH_OP2;
                    end
                end
                PH_OP2: begin
                    push_next  = 1'b1;
                    phase_next = PH_OPC;
                end
                default: phase_next = PH_HHI;
            endcase
            if (in_last) begin
                phase_next = PH_HLO;
            end
        end
    end

    // sequencer and instruction assembly
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_HLO;
            push_reg  <= 1'b0;
            addr_reg  <= '0;
            opc_reg   <= '0;
            opnd_reg  <= '0;
        end else begin
            phase_reg <= phase_next;
            push_reg  <= push_next;
            if (in_fire) begin
                unique case (phase_reg)
                    PH_HHI: begin
                        addr_reg[15:8] <= in_byte;
                    end
                    PH_OPC: begin
                        opc_reg  <= in_byte;
                        mnem_reg <= dec_mnem;
                        mode_reg <= dec_mode;
                        len_reg  <= dec_len;
                        if (dec_len == 2'd1 || in_last) begin
                            push_data_reg.addr   <= addr_reg;
                            push_data_reg.opcode <= in_byte;
                            push_data_reg.op_lo  <= '0;
                            push_data_reg.op_hi  <= '0;
                            push_data_reg.len    <= dec_len;
                            push_data_reg.mode   <= dec_mode;
                            push_data_reg.mnem   <= dec_mnem;
                            push_data_reg.trunc  <= (dec_len != 2'd1);
                            addr_reg             <= addr_reg + {14'd0, dec_len};
                        end
                    end
                    PH_OP1: begin
                        if (len_reg == 2'd2 || in_last) begin
                            push_data_reg.addr   <= addr_reg;
                            push_data_reg.opcode <= opc_reg;
                            push_data_reg.op_lo  <= in_byte;
                            push_data_reg.op_hi  <= '0;
                            push_data_reg.len    <= len_reg;
                            push_data_reg.mode   <= mode_reg;
                            push_data_reg.mnem   <= mnem_reg;
                            push_data_reg.trunc  <= (len_reg != 2'd2);
                            addr_reg             <= addr_reg + {14'd0, len_reg};
                        end else begin
                            opnd_reg <= in_byte;
                        end
                    end
                    PH_OP2: begin
                        push_data_reg.addr   <= addr_reg;
                        push_data_reg.opcode <= opc_reg;
                        push_data_reg.op_lo  <= opnd_reg;
                        push_data_reg.op_hi  <= in_byte;
                        push_data_reg.len    <= len_reg;
                        push_data_reg.mode   <= mode_reg;
                        push_data_reg.mnem   <= mnem_reg;
                        push_data_reg.trunc  <= 1'b0;
                        addr_reg             <= addr_reg + {14'd0, len_reg};
                    end
                    // header low byte; unused phase codes behave the same
                    default: begin
                        addr_reg <= {8'd0, in_byte};
                    end
                endcase
            end
        end
    end

    assign push      = push_reg;
    assign push_data = push_data_reg;

endmodule

// File: sv/m6d_queue.sv
// Short FIFO between front and back
module m6d_queue (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            wr_en,
    input  m6d_pkg::instr_t wr_data,
    input  logic            rd_en,
    output m6d_pkg::instr_t rd_data,
    output logic            rd_valid,
    output logic [1:0]      count
);
    import m6d_pkg::*;

    instr_t     mem [QDEPTH];
    logic       wp_reg;
    logic       rp_reg;
    logic [1:0] cnt_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wp_reg] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= '0;
        end else begin
            if (wr_en) wp_reg <= ~wp_reg;
            if (rd_en) rp_reg <= ~rp_reg;
            cnt_reg <= cnt_reg + {1'b0, wr_en} - {1'b0, rd_en};
        end
    end

    assign rd_data  = mem[rp_reg];
    assign rd_valid = (cnt_reg != 2'd0);
    assign count    = cnt_reg;

endmodule

// File: sv/m6d_back.sv
// Back end: branch target and output register
module m6d_back (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             q_valid,
    input  m6d_pkg::instr_t  q_data,
    output logic             q_pop,
    output logic             m_valid,
    input  logic             m_ready,
    output m6d_pkg::result_t m_data
);
    import m6d_pkg::*;

    `include "mos6502_instruction_stream_decoder_top_assert.svh"

    logic        valid_reg;
    result_t     data_reg;
    logic [15:0] tgt;

    // next address plus sign-extended offset
    always_comb begin
        tgt = '0;
        if (q_data.mode == MODE_REL) begin
            tgt = q_data.addr + {14'd0, q_data.len} + {{8{q_data.op_lo[7]}}, q_data.op_lo};
        end
    end

    assign q_pop = q_valid && (!valid_reg || m_ready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (q_pop) begin
            valid_reg       <= 1'b1;
            data_reg.addr   <= q_data.addr;
            data_reg.opcode <= q_data.opcode;
            data_reg.op_lo  <= q_data.op_lo;
            data_reg.op_hi  <= q_data.op_hi;
            data_reg.len    <= q_data.len;
            data_reg.mode   <= q_data.mode;
            data_reg.mnem   <= q_data.mnem;
            data_reg.target <= tgt;
            data_reg.trunc  <= q_data.trunc;
        end else if (m_ready) begin
            valid_reg <= 1'b0;
        end
    end

    assign m_valid = valid_reg;
    assign m_data  = data_reg;

    `M6D_ASSERT_NEXT(a_hold, aclk, aresetn, valid_reg && !m_ready, valid_reg && $stable(data_reg), "result changed while stalled")
    `M6D_ASSERT_IMPL(a_len, aclk, aresetn, valid_reg, data_reg.len != 2'd0, "zero length")
    `M6D_ASSERT_IMPL(a_tgt, aclk, aresetn, valid_reg && data_reg.mode != MODE_REL, data_reg.target == 16'd0, "target without branch")

endmodule

// File: tb/mos6502_instruction_stream_decoder_top_tb.sv
`timescale 1ns / 1ps

module mos6502_instruction_stream_decoder_top_tb;
    import m6d_pkg::*;

    localparam int IDLE_LIMIT = 20000;
    localparam int DRAIN_CYCLES = 12;

    typedef struct {
        logic [7:0] data;
        logic       last;
    } stream_word_t;

    typedef struct {
        logic [15:0] addr;
        logic [7:0]  opcode;
        logic [7:0]  op_lo;
        logic [7:0]  op_hi;
        logic [1:0]  len;
        logic [3:0]  mode;
        logic [14:0] mnem;
        logic [15:0] target;
        logic        trunc;
    } decoded_t;

    typedef enum logic [2:0] {
        PH_ADDR_LO, PH_ADDR_HI, PH_OPCODE, PH_OPER1, PH_OPER2
    } phase_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = '0;
    logic        s_tlast = 1'b0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic        cfg_data = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [79:0] m_tdata;

    mos6502_instruction_stream_decoder_top uut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready),
        .s_tdata(s_tdata),   // stream_byte
        .s_tlast(s_tlast),   // final_byte
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
        .m_tvalid(m_tvalid), .m_tready(m_tready),
        // instr_address, opcode_byte, operand_low, operand_high, instr_length,
        // address_mode, mnemonic_code, branch_target, truncated, zero pad
        .m_tdata(m_tdata)
    );

    always #10 aclk = ~aclk;

    // stimulus and expectation stores
    stream_word_t pending_bytes[$];
    decoded_t     expected_instrs[$];
    int           mismatches = 0;
    int           instrs_seen = 0;
    int           bytes_sent = 0;
    int           idle_cycles = 0;
    bit           tx_hold = 1'b0;    // sender pause request
    bit           rx_hold = 1'b0;    // long receiver hold-off
    int           trunc_seen = 0;
    int           rel_seen = 0;

    // decoder model state
    phase_t      dec_phase;
    logic [15:0] dec_addr;
    logic [7:0]  dec_opcode;
    logic [7:0]  dec_operand;
    logic        dec_set;
    logic        table_sel;

    // own opcode table: mnemonic letters, documented flag, mode
    function automatic logic [14:0] letters(input string s);
        return {5'(s[0] - 8'd64), 5'(s[1] - 8'd64), 5'(s[2] - 8'd64)};
    endfunction

    function automatic void opcode_info(input logic [7:0] opc, output string mn,
                                        output bit doc, output logic [3:0] md);
        logic [2:0] aaa;
        logic [2:0] bbb;
        logic [1:0] cc;
        string grp1[8] = '{"ORA", "AND", "EOR", "ADC", "STA", "LDA", "CMP", "SBC"};
        string grp2[8] = '{"ASL", "ROL", "LSR", "ROR", "STX", "LDX", "DEC", "INC"};
        string ill3[8] = '{"SLO", "RLA", "SRE", "RRA", "SAX", "LAX", "DCP", "ISC"};
        string imp0[8] = '{"PHP", "PLP", "PHA", "PLA", "DEY", "TAY", "INY", "INX"};
        string clr0[8] = '{"CLC", "SEC", "CLI", "SEI", "TYA", "CLV", "CLD", "SED"};
        string br[8]   = '{"BPL", "BMI", "BVC", "BVS", "BCC", "BCS", "BNE", "BEQ"};
        logic [3:0] m1[8] = '{MODE_IZX, MODE_ZPG, MODE_IMM, MODE_ABS,
                              MODE_IZY, MODE_ZPX, MODE_ABY, MODE_ABX};
        aaa = opc[7:5];
        bbb = opc[4:2];
        cc = opc[1:0];
        mn = "NOP";
        doc = 1'b0;
        md = MODE_IMP;
        case (cc)
            2'd1: begin
                mn = grp1[aaa];
                md = m1[bbb];
                doc = !(opc == 8'h89);
                if (opc == 8'h89) mn = "NOP";
            end
            2'd3: begin
                mn = ill3[aaa];
                md = m1[bbb];
                case (opc)
                    8'h0B, 8'h2B: mn = "ANC";
                    8'h4B: mn = "ALR";
                    8'h6B: mn = "ARR";
                    8'h8B: mn = "XAA";
                    8'hAB: mn = "LAX";
                    8'hCB: mn = "AXS";
                    8'hEB: mn = "SBC";
                    8'h93, 8'h9F: mn = "AHX";
                    8'h9B: mn = "TAS";
                    8'hBB: mn = "LAS";
                    default: ;
                endcase
                if (opc == 8'h97 || opc == 8'hB7) md = MODE_ZPY;
                if (opc == 8'hBF || opc == 8'h9F) md = MODE_ABY;
            end
            2'd2: begin
                case (bbb)
                    3'd0: begin
                        if (aaa >= 3'd4) begin
                            md = MODE_IMM;
                            if (aaa == 3'd5) begin mn = "LDX"; doc = 1'b1; end
                        end else begin
                            mn = "KIL";
                        end
                    end
                    3'd4: mn = "KIL";
                    3'd2: begin
                        md = MODE_IMP;
                        doc = 1'b1;
                        case (aaa)
                            3'd4: mn = "TXA";
                            3'd5: mn = "TAX";
                            3'd6: mn = "DEX";
                            3'd7: mn = "NOP";
                            default: mn = grp2[aaa];
                        endcase
                    end
                    3'd6: begin
                        md = MODE_IMP;
                        doc = (aaa == 3'd4 || aaa == 3'd5);
                        mn = (aaa == 3'd4) ? "TXS" : (aaa == 3'd5) ? "TSX" : "NOP";
                    end
                    default: begin
                        md = (bbb == 3'd1) ? MODE_ZPG : (bbb == 3'd3) ? MODE_ABS :
                             (bbb == 3'd5) ? MODE_ZPX : MODE_ABX;
                        mn = grp2[aaa];
                        doc = 1'b1;
                        if (aaa == 3'd4 || aaa == 3'd5) begin
                            if (bbb == 3'd5) md = MODE_ZPY;
                            if (bbb == 3'd7) md = MODE_ABY;
                        end
                        if (opc == 8'h9E) begin mn = "SHX"; doc = 1'b0; end
                    end
                endcase
            end
            default: begin
                case (bbb)
                    3'd0: begin
                        case (aaa)
                            3'd0: begin mn = "BRK"; doc = 1'b1; end
                            3'd1: begin mn = "JSR"; doc = 1'b1; md = MODE_ABS; end
                            3'd2: begin mn = "RTI"; doc = 1'b1; end
                            3'd3: begin mn = "RTS"; doc = 1'b1; end
                            3'd4: md = MODE_IMM;
                            3'd5: begin mn = "LDY"; doc = 1'b1; md = MODE_IMM; end
                            3'd6: begin mn = "CPY"; doc = 1'b1; md = MODE_IMM; end
                            default: begin mn = "CPX"; doc = 1'b1; md = MODE_IMM; end
                        endcase
                    end
                    3'd2: begin mn = imp0[aaa]; doc = 1'b1; end
                    3'd4: begin mn = br[aaa]; doc = 1'b1; md = MODE_REL; end
                    3'd6: begin mn = clr0[aaa]; doc = 1'b1; end
                    default: begin
                        md = (bbb == 3'd1) ? MODE_ZPG : (bbb == 3'd3) ? MODE_ABS :
                             (bbb == 3'd5) ? MODE_ZPX : MODE_ABX;
                        case (aaa)
                            3'd1: if (bbb == 3'd1 || bbb == 3'd3) begin
                                mn = "BIT"; doc = 1'b1;
                            end
                            3'd2: if (bbb == 3'd3) begin mn = "JMP"; doc = 1'b1; end
                            3'd3: if (bbb == 3'd3) begin
                                mn = "JMP"; doc = 1'b1; md = MODE_IND;
                            end
                            3'd4: begin
                                mn = "STY";
                                doc = (bbb != 3'd7);
                                if (bbb == 3'd7) mn = "SHY";
                            end
                            3'd5: begin mn = "LDY"; doc = 1'b1; end
                            3'd6: if (bbb != 3'd5 && bbb != 3'd7) begin
                                mn = "CPY"; doc = 1'b1;
                            end
                            3'd7: if (bbb != 3'd5 && bbb != 3'd7) begin
                                mn = "CPX"; doc = 1'b1;
                            end
                            default: ;
                        endcase
                    end
                endcase
            end
        endcase
    endfunction

    // effective table entry under a given table select
    function automatic void lookup(input logic [7:0] opc, input logic sel,
                                   output logic [14:0] mnem, output logic [3:0] md,
                                   output logic [1:0] len);
        string mn;
        bit doc;
        opcode_info(opc, mn, doc, md);
        mnem = letters(mn);
        if (!sel && !doc) begin
            mnem = '0;
            md = MODE_IMP;
        end
        case (md)
            MODE_IMP: len = 2'd1;
            MODE_ABS, MODE_ABX, MODE_ABY, MODE_IND: len = 2'd3;
            default: len = 2'd2;
        endcase
    endfunction

    function automatic void push_instr(input logic [7:0] lo, input logic [7:0] hi,
                                       input logic trunc);
        decoded_t d;
        lookup(dec_opcode, dec_set, d.mnem, d.mode, d.len);
        d.addr = dec_addr;
        d.opcode = dec_opcode;
        d.op_lo = lo;
        d.op_hi = hi;
        d.trunc = trunc;
        d.target = (d.mode == MODE_REL) ?
                   dec_addr + 16'(d.len) + {{8{lo[7]}}, lo} : 16'h0000;
        expected_instrs.push_back(d);
        dec_addr = dec_addr + 16'(d.len);
    endfunction

    // advance the decoder model by one accepted byte
    function automatic void decode_byte(input logic [7:0] b, input logic fin);
        logic [14:0] mn;
        logic [3:0]  md;
        logic [1:0]  len;
        case (dec_phase)
            PH_ADDR_HI: begin
                dec_addr[15:8] = b;
                dec_phase = PH_OPCODE;
            end
            PH_OPCODE: begin
                dec_opcode = b;
                dec_set = table_sel;
                lookup(b, dec_set, mn, md, len);
                if (len == 2'd1) push_instr(8'h00, 8'h00, 1'b0);
                else if (fin) push_instr(8'h00, 8'h00, 1'b1);
                else dec_phase = PH_OPER1;
            end
            PH_OPER1: begin
                lookup(dec_opcode, dec_set, mn, md, len);
                if (len == 2'd2) begin
                    push_instr(b, 8'h00, 1'b0);
                    dec_phase = PH_OPCODE;
                end else if (fin) begin
                    push_instr(b, 8'h00, 1'b1);
                end else begin
                    dec_operand = b;
                    dec_phase = PH_OPER2;
                end
            end
            PH_OPER2: begin
                push_instr(dec_operand, b, 1'b0);
                dec_phase = PH_OPCODE;
            end
            default: begin
                dec_addr = {8'h00, b};
                dec_phase = PH_ADDR_HI;
            end
        endcase
        if (fin) dec_phase = PH_ADDR_LO;
    endfunction

    task automatic report_mismatch(input string what, input logic [15:0] got,
                                   input logic [15:0] want);
        $display("mismatch on instruction %0d: %s got 0x%0h expected 0x%0h",
                 instrs_seen, what, got, want);
        mismatches++;
    endtask

    // input driver
    always @(posedge aclk) begin
        stream_word_t w;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                decode_byte(s_tdata, s_tlast);
                bytes_sent++;
            end
            if (!(s_tvalid && !s_tready)) begin
                if (pending_bytes.size() > 0 && !tx_hold &&
                    $urandom_range(0, 99) >= ((bytes_sent / 200) % 3 == 0 ? 0 : 20)) begin
                    w = pending_bytes.pop_front();
                    s_tdata <= w.data;
                    s_tlast <= w.last;
                    s_tvalid <= 1'b1;
                end else begin
                    s_tvalid <= 1'b0;
                    if (pending_bytes.size() > 0 && $urandom_range(0, 99) < 3)
                        tx_hold = 1'b1;
                end
            end
            if (tx_hold && $urandom_range(0, 9) == 0) tx_hold = 1'b0;
        end
    end

    // result monitor and receiver
    always @(posedge aclk) begin
        decoded_t g;
        decoded_t e;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                g.addr   = m_tdata[15:0];
                g.opcode = m_tdata[23:16];
                g.op_lo  = m_tdata[31:24];
                g.op_hi  = m_tdata[39:32];
                g.len    = m_tdata[41:40];
                g.mode   = m_tdata[45:42];
                g.mnem   = m_tdata[60:46];
                g.target = m_tdata[76:61];
                g.trunc  = m_tdata[77];
                if (expected_instrs.size() == 0) begin
                    $display("unexpected instruction word 0x%0h", m_tdata);
                    mismatches++;
                end else begin
                    e = expected_instrs.pop_front();
                    if (g.addr !== e.addr) report_mismatch("address", g.addr, e.addr);
                    if (g.opcode !== e.opcode)
                        report_mismatch("opcode", 16'(g.opcode), 16'(e.opcode));
                    if (g.op_lo !== e.op_lo)
                        report_mismatch("operand low", 16'(g.op_lo), 16'(e.op_lo));
                    if (g.op_hi !== e.op_hi)
                        report_mismatch("operand high", 16'(g.op_hi), 16'(e.op_hi));
                    if (g.len !== e.len)
                        report_mismatch("length", 16'(g.len), 16'(e.len));
                    if (g.mode !== e.mode)
                        report_mismatch("mode", 16'(g.mode), 16'(e.mode));
                    if (g.mnem !== e.mnem)
                        report_mismatch("mnemonic", 16'(g.mnem), 16'(e.mnem));
                    if (g.target !== e.target) report_mismatch("target", g.target, e.target);
                    if (g.trunc !== e.trunc)
                        report_mismatch("truncated", 16'(g.trunc), 16'(e.trunc));
                    if (e.trunc) trunc_seen++;
                    if (e.mode == MODE_REL) rel_seen++;
                end
                instrs_seen++;
            end
            m_tready <= !rx_hold && ($urandom_range(0, 99) >= 25 || (instrs_seen / 150) % 2 == 1);
        end
    end

    // stall watchdog
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !aresetn ||
            (pending_bytes.size() == 0 && expected_instrs.size() == 0 && !s_tvalid))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("watchdog: no progress for %0d cycles", IDLE_LIMIT);
            $display("CHECKS FAILED");
            $finish;
        end
    end

    task automatic put_byte(input logic [7:0] b, input logic fin);
        stream_word_t w;
        w.data = b;
        w.last = fin;
        pending_bytes.push_back(w);
    endtask

    // a random well-formed image, sometimes ending mid-instruction
    task automatic build_image(input int n_instr, input bit cut_short);
        logic [7:0]  opc;
        logic [14:0] mn;
        logic [3:0]  md;
        logic [1:0]  len;
        put_byte(8'($urandom), 1'b0);
        put_byte(8'($urandom), 1'b0);
        for (int i = 0; i < n_instr; i++) begin
            opc = 8'($urandom);
            lookup(opc, table_sel, mn, md, len);
            if (i == n_instr - 1 && cut_short && len > 2'd1) begin
                put_byte(opc, len == 2'd2 || $urandom_range(0, 1) == 0);
                if (!pending_bytes[$].last) put_byte(8'($urandom), 1'b1);
                return;
            end
            put_byte(opc, i == n_instr - 1 && len == 2'd1);
            for (int k = 1; k < len; k++)
                put_byte(8'($urandom), i == n_instr - 1 && k == len - 1);
        end
    endtask

    task automatic wait_drained();
        while (pending_bytes.size() > 0 || s_tvalid || expected_instrs.size() > 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic write_table_sel(input logic v);
        cfg_data <= v;
        cfg_valid <= 1'b1;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
        table_sel = v;
    endtask

    initial begin
        dec_phase = PH_ADDR_LO;
        dec_addr = '0;
        dec_opcode = '0;
        dec_operand = '0;
        dec_set = 1'b0;
        table_sel = 1'b0;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: reset table, short headers, wrap, branches, truncation
        put_byte(8'hFF, 1'b1);                        // image ends on header low
        put_byte(8'h34, 1'b0); put_byte(8'h12, 1'b1); // ends on header high
        put_byte(8'hFE, 1'b0); put_byte(8'hFF, 1'b0); // load at top of memory
        put_byte(8'h02, 1'b0);                        // undocumented, length 1 here
        put_byte(8'hD0, 1'b0); put_byte(8'h80, 1'b0); // backward branch
        put_byte(8'h10, 1'b0); put_byte(8'h7F, 1'b0); // forward branch
        put_byte(8'hFF, 1'b0); put_byte(8'h6C, 1'b0);
        put_byte(8'hFF, 1'b0); put_byte(8'hFF, 1'b0); // indirect jump
        put_byte(8'hAD, 1'b0); put_byte(8'h00, 1'b1); // abs cut after one operand
        put_byte(8'h00, 1'b0); put_byte(8'h00, 1'b0);
        put_byte(8'hF0, 1'b1);                        // branch cut at opcode
        wait_drained();

        write_table_sel(1'b1);
        put_byte(8'h00, 1'b0); put_byte(8'h80, 1'b0);
        put_byte(8'h02, 1'b0); put_byte(8'hFF, 1'b0); put_byte(8'h55, 1'b0);
        put_byte(8'hAA, 1'b0); put_byte(8'h97, 1'b0); put_byte(8'h01, 1'b0);
        put_byte(8'hEB, 1'b1);                        // imm cut at opcode
        wait_drained();

        // random phases with alternating table select
        for (int ph = 0; ph < 6; ph++) begin
            write_table_sel(ph % 2 == 0 ? 1'b0 : 1'b1);
            while (pending_bytes.size() < 280) begin
                if ($urandom_range(0, 9) == 0)
                    put_byte(8'($urandom), $urandom_range(0, 3) == 0);
                else
                    build_image($urandom_range(1, 25), $urandom_range(0, 3) == 0);
            end
            if (ph == 2) begin
                // long receiver hold-off while bytes keep coming
                rx_hold = 1'b1;
                repeat (300) @(posedge aclk);
                rx_hold = 1'b0;
            end
            wait_drained();
        end

        $display("sent %0d bytes, checked %0d instructions (%0d relative, %0d truncated)",
                 bytes_sent, instrs_seen, rel_seen, trunc_seen);
        $display("both opcode tables exercised, with random idling on both sides");
        if (mismatches == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
